### design/mfr_pkg.sv
// Shared types and constants for the meter frame receiver.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package mfr_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROTOCOL_2007   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_ADDR   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_ID     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESPONSE_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTE_TIMEOUT    = 3'd4;

    localparam logic [7:0] START_BYTE     = 8'h68;
    localparam logic [7:0] END_BYTE       = 8'h16;
    localparam logic [7:0] DATA_OFFSET    = 8'h33;
    localparam logic [7:0] ADDR_WILDCARD  = 8'hAA;
    localparam logic [7:0] ADDR_BROADCAST = 8'h99;
    localparam logic [7:0] EXCEPTION_BIT  = 8'h40;

    localparam logic [47:0] RESET_ADDRESS       = 48'hAAAA_AAAA_AAAA;
    localparam logic [15:0] RESET_RESP_TIMEOUT  = 16'd100;
    localparam logic [15:0] RESET_BYTE_TIMEOUT  = 16'd500 / 16'd10;

    // header is bytes 0..9, data starts at 10
    localparam logic [8:0] POS_FIRST_ADDR = 9'd1;
    localparam logic [8:0] POS_LAST_ADDR  = 9'd6;
    localparam logic [8:0] POS_SECOND_START = 9'd7;
    localparam logic [8:0] POS_CONTROL    = 9'd8;
    localparam logic [8:0] POS_LENGTH     = 9'd9;
    localparam logic [8:0] POS_DATA       = 9'd10;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_ACCEPTED   = 3'd0,
        EV_FRAME_OK   = 3'd1,
        EV_CHECKSUM   = 3'd2,
        EV_FRAMING    = 3'd3,
        EV_ADDRESS    = 3'd4,
        EV_EXCEPTION  = 3'd5,
        EV_IDENTIFIER = 3'd6,
        EV_TIMEOUT    = 3'd7
    } t_event;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_event     event_res;
        logic [8:0] position;
        logic [7:0] value;
        logic       is_payload;
        logic [7:0] payload_length;
    } t_out_item;

    typedef struct packed {
        logic            protocol_2007;
        logic [5:0][7:0] expected_address;
        logic [3:0][7:0] expected_identifier;
        logic [15:0]     response_timeout_ticks;
        logic [15:0]     byte_timeout_ticks;
    } t_cfg;

endpackage

`default_nettype wire

### design/mfr_cfg_regs.sv
// Configuration register file of the meter frame receiver.
// Depends on mfr_pkg for the register indexes and the t_cfg struct.
`default_nettype none

module mfr_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mfr_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [mfr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output mfr_pkg::t_cfg                            o_cfg
);

    mfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol_2007          <= 1'b1;
            r_cfg.expected_address       <= mfr_pkg::RESET_ADDRESS;
            r_cfg.expected_identifier    <= '0;
            r_cfg.response_timeout_ticks <= mfr_pkg::RESET_RESP_TIMEOUT;
            r_cfg.byte_timeout_ticks     <= mfr_pkg::RESET_BYTE_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfr_pkg::CFG_PROTOCOL_2007: begin
                    r_cfg.protocol_2007 <= i_cfg_data[0];
                end
                mfr_pkg::CFG_EXPECTED_ADDR: begin
                    r_cfg.expected_address <= i_cfg_data[47:0];
                end
                mfr_pkg::CFG_EXPECTED_ID: begin
                    r_cfg.expected_identifier <= i_cfg_data[31:0];
                end
                mfr_pkg::CFG_RESPONSE_TIMEOUT: begin
                    r_cfg.response_timeout_ticks <= i_cfg_data[15:0];
                end
                mfr_pkg::CFG_BYTE_TIMEOUT: begin
                    r_cfg.byte_timeout_ticks <= i_cfg_data[15:0];
                end
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/mfr_frame_core.sv
// Frame tracking state and per-item decision logic of the meter frame receiver.
// Depends on mfr_pkg for item structs, event codes and frame constants.
`default_nettype none

module mfr_frame_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire mfr_pkg::t_in_item i_item,
    input  wire mfr_pkg::t_cfg i_cfg,
    output logic            o_res_valid,
    output mfr_pkg::t_out_item o_res_item
);

    logic                  r_receiving,  n_receiving;
    logic [8:0]            r_byte_count, n_byte_count;
    logic [7:0]            r_frame_length, n_frame_length;
    logic [7:0]            r_checksum_sum, n_checksum_sum;
    logic                  r_address_match, n_address_match;
    logic                  r_exception_seen, n_exception_seen;
    logic                  r_identifier_match, n_identifier_match;
    logic [TIMER_BITS-1:0] r_countdown, n_countdown;

    logic [8:0]            pos;
    logic [8:0]            data_end;
    logic [8:0]            data_idx;
    logic [7:0]            rx;
    logic [7:0]            data_value;
    logic [7:0]            addr_exp;
    logic [2:0]            addr_sel;
    logic [2:0]            id_len;
    logic                  broadcast;
    logic [TIMER_BITS-1:0] cd_dec;

    assign pos        = r_byte_count;
    assign rx         = i_item.rx_byte;
    assign data_end   = {1'b0, r_frame_length} + mfr_pkg::POS_DATA;
    assign data_idx   = pos - mfr_pkg::POS_DATA;
    assign data_value = rx - mfr_pkg::DATA_OFFSET;
    assign id_len     = i_cfg.protocol_2007 ? 3'd4 : 3'd2;
    assign addr_sel   = pos[2:0] - 3'd1;
    assign broadcast  = !i_cfg.protocol_2007
                        && (i_cfg.expected_address == {6{mfr_pkg::ADDR_BROADCAST}});
    assign cd_dec     = (r_countdown != '0) ? r_countdown - 1'b1 : r_countdown;

    always_comb begin
        case (addr_sel)
            3'd0:    addr_exp = i_cfg.expected_address[0];
            3'd1:    addr_exp = i_cfg.expected_address[1];
            3'd2:    addr_exp = i_cfg.expected_address[2];
            3'd3:    addr_exp = i_cfg.expected_address[3];
            3'd4:    addr_exp = i_cfg.expected_address[4];
            3'd5:    addr_exp = i_cfg.expected_address[5];
            default: addr_exp = '0;
        endcase
    end

    always_comb begin
        n_receiving        = r_receiving;
        n_byte_count       = r_byte_count;
        n_frame_length     = r_frame_length;
        n_checksum_sum     = r_checksum_sum;
        n_address_match    = r_address_match;
        n_exception_seen   = r_exception_seen;
        n_identifier_match = r_identifier_match;
        n_countdown        = r_countdown;

        o_res_valid               = 1'b0;
        o_res_item.event_res      = mfr_pkg::EV_ACCEPTED;
        o_res_item.position       = pos;
        o_res_item.value          = rx;
        o_res_item.is_payload     = 1'b0;
        o_res_item.payload_length = r_frame_length;

        if (i_accept) begin
            case (mfr_pkg::t_mode'(i_item.mode))
                mfr_pkg::MODE_START: begin
                    n_receiving        = 1'b1;
                    n_byte_count       = '0;
                    n_frame_length     = '0;
                    n_checksum_sum     = '0;
                    n_address_match    = 1'b1;
                    n_exception_seen   = 1'b0;
                    n_identifier_match = 1'b1;
                    n_countdown        = TIMER_BITS'(i_cfg.response_timeout_ticks);
                end
                mfr_pkg::MODE_TICK: begin
                    if (r_receiving) begin
                        n_countdown = cd_dec;
                        if (cd_dec == '0) begin
                            n_receiving               = 1'b0;
                            o_res_valid               = 1'b1;
                            o_res_item.event_res      = mfr_pkg::EV_TIMEOUT;
                            o_res_item.value          = '0;
                            o_res_item.payload_length = '0;
                        end
                    end
                end
                mfr_pkg::MODE_BYTE: begin
                    if (r_receiving) begin
                        n_countdown = TIMER_BITS'(i_cfg.byte_timeout_ticks);
                        o_res_valid = 1'b1;
                        if ((pos == '0 || pos == mfr_pkg::POS_SECOND_START)
                                && rx != mfr_pkg::START_BYTE) begin
                            // resync; the bad byte is not taken as a new start
                            n_byte_count              = '0;
                            n_frame_length            = '0;
                            n_checksum_sum            = '0;
                            n_address_match           = 1'b1;
                            n_exception_seen          = 1'b0;
                            n_identifier_match        = 1'b1;
                            o_res_item.event_res      = mfr_pkg::EV_FRAMING;
                            o_res_item.payload_length = '0;
                        end else if (pos <= mfr_pkg::POS_LENGTH) begin
                            if (pos >= mfr_pkg::POS_FIRST_ADDR && pos <= mfr_pkg::POS_LAST_ADDR
                                    && !(i_cfg.protocol_2007
                                         && addr_exp == mfr_pkg::ADDR_WILDCARD)
                                    && rx != addr_exp) begin
                                n_address_match = 1'b0;
                            end
                            if (pos == mfr_pkg::POS_CONTROL
                                    && (rx & mfr_pkg::EXCEPTION_BIT) != '0) begin
                                n_exception_seen = 1'b1;
                            end
                            if (pos == mfr_pkg::POS_LENGTH) begin
                                n_frame_length            = rx;
                                o_res_item.payload_length = rx;
                            end else begin
                                o_res_item.payload_length = '0;
                            end
                            n_checksum_sum = r_checksum_sum + rx;
                            n_byte_count   = pos + 9'd1;
                        end else if (pos < data_end) begin
                            if ({6'd0, id_len} > data_idx
                                    && data_value
                                       != i_cfg.expected_identifier[data_idx[1:0]]) begin
                                n_identifier_match = 1'b0;
                            end
                            n_checksum_sum        = r_checksum_sum + rx;
                            n_byte_count          = pos + 9'd1;
                            o_res_item.value      = data_value;
                            o_res_item.is_payload = 1'b1;
                        end else if (pos == data_end) begin
                            // checksum byte: running sum returns to zero when it matches
                            n_checksum_sum = r_checksum_sum - rx;
                            n_byte_count   = pos + 9'd1;
                        end else if (rx != mfr_pkg::END_BYTE
                                     || r_checksum_sum != '0) begin
                            n_byte_count         = '0;
                            n_frame_length       = '0;
                            n_checksum_sum       = '0;
                            n_address_match      = 1'b1;
                            n_exception_seen     = 1'b0;
                            n_identifier_match   = 1'b1;
                            o_res_item.event_res = (rx != mfr_pkg::END_BYTE)
                                                   ? mfr_pkg::EV_FRAMING
                                                   : mfr_pkg::EV_CHECKSUM;
                        end else begin
                            n_byte_count = pos + 9'd1;
                            n_receiving  = 1'b0;
                            if (!(broadcast || r_address_match)) begin
                                o_res_item.event_res = mfr_pkg::EV_ADDRESS;
                            end else if (r_exception_seen) begin
                                o_res_item.event_res = mfr_pkg::EV_EXCEPTION;
                            end else if (!r_identifier_match
                                         || r_frame_length < {5'd0, id_len}) begin
                                o_res_item.event_res = mfr_pkg::EV_IDENTIFIER;
                            end else begin
                                o_res_item.event_res = mfr_pkg::EV_FRAME_OK;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving        <= 1'b0;
            r_byte_count       <= '0;
            r_frame_length     <= '0;
            r_checksum_sum     <= '0;
            r_address_match    <= 1'b1;
            r_exception_seen   <= 1'b0;
            r_identifier_match <= 1'b1;
            r_countdown        <= '0;
        end else begin
            r_receiving        <= n_receiving;
            r_byte_count       <= n_byte_count;
            r_frame_length     <= n_frame_length;
            r_checksum_sum     <= n_checksum_sum;
            r_address_match    <= n_address_match;
            r_exception_seen   <= n_exception_seen;
            r_identifier_match <= n_identifier_match;
            r_countdown        <= n_countdown;
        end
    end

endmodule

`default_nettype wire

### design/mfr_out_skid.sv
// Result register with a skid entry for the meter frame receiver.
// Depends on mfr_pkg for the t_out_item struct.
`default_nettype none

module mfr_out_skid (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mfr_pkg::t_out_item i_item,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output mfr_pkg::t_out_item o_out_item,
    output logic               o_full
);

    logic               r_out_valid;
    logic               r_skid_valid;
    mfr_pkg::t_out_item r_out_item;
    mfr_pkg::t_out_item r_skid_item;
    logic               out_free;

    // a push only comes while the skid entry is empty
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else begin
            r_skid_valid <= r_skid_valid || i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_item <= r_skid_valid ? r_skid_item : i_item;
            if (i_push) begin
                r_skid_item <= i_item;
            end
        end else if (i_push) begin
            r_skid_item <= i_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_full      = r_skid_valid;

endmodule

`default_nettype wire

### design/meter_frame_receiver.sv
// Top level of the meter frame receiver: config registers, frame core, result buffer.
// Depends on mfr_pkg, mfr_cfg_regs, mfr_frame_core and mfr_out_skid.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------
//   input    | i_in_valid / o_in_stall  | i_in_item  (mode, rx_byte)
//   result   | o_out_valid / i_out_stall| o_out_item (event_res .. payload_length)
//   config   | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low; frame state and any result are registered
// at the accepting edge, the result into the output register or into the skid entry.
// Reset is synchronous and restores the configuration defaults; no clearing pass.
// A stalled result parks in the one-entry skid; o_in_stall rises only while it is full.
`default_nettype none

module meter_frame_receiver #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire mfr_pkg::t_in_item                   i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output mfr_pkg::t_out_item                       o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [mfr_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [mfr_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    mfr_pkg::t_cfg      cfg;
    mfr_pkg::t_out_item res_item;
    logic               res_valid;
    logic               accept;
    logic               skid_full;

    assign o_in_stall = skid_full;
    assign accept     = i_in_valid && !skid_full;

    mfr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mfr_frame_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_frame_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res_item  (res_item)
    );

    mfr_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_item      (res_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_full      (skid_full)
    );

endmodule

`default_nettype wire

### design/mfr_checker.sv
// Port-level checks for the meter frame receiver, bound to the top level.
// Depends on mfr_pkg for event codes and the item structs.
`default_nettype none

module mfr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire mfr_pkg::t_out_item o_out_item
);

    // results waiting at the port are not dropped or altered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or vanished while stalled");

    // reset leaves no result and no back-pressure
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present right after reset");

    // data bytes are only reported as accepted bytes past the header
    a_payload_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_payload
        |-> o_out_item.event_res == mfr_pkg::EV_ACCEPTED
            && o_out_item.position >= mfr_pkg::POS_DATA)
        else $error("payload flag on a non-data result");

    // a timeout carries no byte information
    a_timeout_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_res == mfr_pkg::EV_TIMEOUT
        |-> o_out_item.value == '0 && !o_out_item.is_payload
            && o_out_item.payload_length == '0)
        else $error("timeout result carries byte fields");

    // stall can only come from a result parked behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind meter_frame_receiver mfr_checker u_mfr_checker (.*);

`default_nettype wire
